@@ sv/rea_pkg.sv @@
`default_nettype none

package rea_pkg;

   // Pool size; widths below follow from it. Valid range is 2 to 256.
   localparam int NUM_ENTRIES = 64;
   localparam int SLOT_W      = $clog2(NUM_ENTRIES);
   localparam int FILL_W      = $clog2(NUM_ENTRIES + 1);

   localparam int CMD_W    = 2;
   localparam int IDX_W    = 8;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 8;

   localparam logic [COUNT_W-1:0] COUNT_LIMIT = 8'd255;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_RETAIN  = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_NOP     = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 3'd0,
      STAT_EMPTY      = 3'd1,
      STAT_SATURATED  = 3'd2,
      STAT_NOT_IN_USE = 3'd3,
      STAT_FREED      = 3'd4
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
   } ctl_cmd_type;

endpackage

`default_nettype wire

@@ sv/rea_ctrl.sv @@
`default_nettype none

module rea_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   output logic                      rsp_valid,
   output rea_pkg::ctl_cmd_type      ctl
);
   import rea_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == S_EXEC);
      end
   end

   assign busy     = (state_ff != S_IDLE);
   assign ctl.load = start && (state_ff == S_IDLE);
   assign ctl.exec = (state_ff == S_EXEC);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_accept_goes_exec : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_EXEC))
      else $error("accepted transaction did not enter execute");
   a_exec_gives_result : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("execute cycle did not produce exactly one result");
   a_result_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for more than one cycle");
`endif

endmodule

`default_nettype wire

@@ sv/rea_datapath.sv @@
`default_nettype none

module rea_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire rea_pkg::ctl_cmd_type          ctl,
   input  wire logic [rea_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [rea_pkg::IDX_W-1:0]     req_entry_index,
   output logic [rea_pkg::STATUS_W-1:0]       rsp_status,
   output logic [rea_pkg::IDX_W-1:0]          rsp_result_index,
   output logic [rea_pkg::COUNT_W-1:0]        rsp_ref_count
);
   import rea_pkg::*;

   // Free-index stack. A slot never pushed since reset reads as its own index.
   logic [SLOT_W-1:0]      stack_mem [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] stack_vld_ff;
   logic [COUNT_W-1:0]     count_mem [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] in_use_ff;
   logic [FILL_W-1:0]      free_count_ff;
   logic [FILL_W-1:0]      free_count_in;

   // Transaction captured at acceptance, with the registered memory reads.
   cmd_type                cmd_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic                   live_ff;
   logic [SLOT_W-1:0]      top_rd_ff;
   logic [SLOT_W-1:0]      top_slot_ff;
   logic                   top_vld_ff;
   logic [COUNT_W-1:0]     cnt_rd_ff;

   logic                   req_in_range;
   logic [SLOT_W-1:0]      req_slot;
   logic [SLOT_W-1:0]      top_slot;
   logic [SLOT_W-1:0]      top_entry;
   logic [SLOT_W-1:0]      idx_slot;
   logic [SLOT_W-1:0]      push_slot;

   status_type             status_in;
   logic [IDX_W-1:0]       index_in;
   logic [COUNT_W-1:0]     count_in;
   logic                   cnt_we;
   logic [SLOT_W-1:0]      cnt_waddr;
   logic [COUNT_W-1:0]     cnt_wdata;
   logic                   use_set;
   logic                   use_clr;
   logic [SLOT_W-1:0]      use_addr;
   logic                   push;

   status_type             rsp_status_ff;
   logic [IDX_W-1:0]       rsp_index_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;

   assign req_in_range = (int'(req_entry_index) < NUM_ENTRIES);
   assign req_slot     = req_in_range ? req_entry_index[SLOT_W-1:0] : '0;
   assign top_slot     = (free_count_ff != '0) ? SLOT_W'(free_count_ff - 1'b1) : '0;
   assign top_entry    = top_vld_ff ? top_rd_ff : top_slot_ff;
   assign idx_slot     = idx_ff[SLOT_W-1:0];
   assign push_slot    = SLOT_W'(free_count_ff);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff      <= cmd_type'(req_cmd);
         idx_ff      <= req_entry_index;
         live_ff     <= req_in_range && in_use_ff[req_slot];
         top_rd_ff   <= stack_mem[top_slot];
         top_slot_ff <= top_slot;
         top_vld_ff  <= stack_vld_ff[top_slot];
         cnt_rd_ff   <= count_mem[req_slot];
      end
   end

   always_comb begin
      status_in     = STAT_OK;
      index_in      = idx_ff;
      count_in      = '0;
      free_count_in = free_count_ff;
      cnt_we        = 1'b0;
      cnt_waddr     = idx_slot;
      cnt_wdata     = '0;
      use_set       = 1'b0;
      use_clr       = 1'b0;
      use_addr      = idx_slot;
      push          = 1'b0;
      case (cmd_ff)
         CMD_ALLOC: begin
            if (free_count_ff == '0) begin
               status_in = STAT_EMPTY;
               index_in  = '0;
            end else begin
               free_count_in = FILL_W'(free_count_ff - 1'b1);
               cnt_we        = 1'b1;
               cnt_waddr     = top_entry;
               use_set       = 1'b1;
               use_addr      = top_entry;
               index_in      = IDX_W'(top_entry);
            end
         end
         CMD_RETAIN: begin
            if (!live_ff) begin
               status_in = STAT_NOT_IN_USE;
            end else if (cnt_rd_ff == COUNT_LIMIT) begin
               status_in = STAT_SATURATED;
               count_in  = COUNT_LIMIT;
            end else begin
               cnt_we    = 1'b1;
               cnt_wdata = COUNT_W'(cnt_rd_ff + 1'b1);
               count_in  = COUNT_W'(cnt_rd_ff + 1'b1);
            end
         end
         CMD_RELEASE: begin
            if (!live_ff) begin
               status_in = STAT_NOT_IN_USE;
            end else if (cnt_rd_ff != '0) begin
               cnt_we    = 1'b1;
               cnt_wdata = COUNT_W'(cnt_rd_ff - 1'b1);
               count_in  = COUNT_W'(cnt_rd_ff - 1'b1);
            end else begin
               // Last reference gone: return the index to the free stack.
               status_in = STAT_FREED;
               use_clr   = 1'b1;
               if (int'(free_count_ff) < NUM_ENTRIES) begin
                  push          = 1'b1;
                  free_count_in = FILL_W'(free_count_ff + 1'b1);
               end
            end
         end
         CMD_NOP: begin
            status_in = STAT_OK;
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= FILL_W'(NUM_ENTRIES);
         in_use_ff     <= '0;
         stack_vld_ff  <= '0;
      end else if (ctl.exec) begin
         free_count_ff <= free_count_in;
         if (use_set) in_use_ff[use_addr] <= 1'b1;
         if (use_clr) in_use_ff[use_addr] <= 1'b0;
         if (push) stack_vld_ff[push_slot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec && push) begin
         stack_mem[push_slot] <= idx_slot;
      end
      if (ctl.exec && cnt_we) begin
         count_mem[cnt_waddr] <= cnt_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec) begin
         rsp_status_ff <= status_in;
         rsp_index_ff  <= index_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_ref_count    = rsp_count_ff;

`ifndef ASSERT_OFF
   a_fill_bounded : assert property (@(posedge clock) disable iff (reset)
      int'(free_count_ff) <= NUM_ENTRIES)
      else $error("free count exceeds pool size");
   a_pool_conserved : assert property (@(posedge clock) disable iff (reset)
      ($countones(in_use_ff) + int'(free_count_ff)) == NUM_ENTRIES)
      else $error("in-use entries plus free entries differ from pool size");
   a_alloc_free_entry : assert property (@(posedge clock) disable iff (reset)
      (ctl.exec && cmd_ff == CMD_ALLOC && free_count_ff != '0) |-> !in_use_ff[top_entry])
      else $error("free stack handed out an entry already in use");
`endif

endmodule

`default_nettype wire

@@ sv/refcounted_entry_allocator_unit.sv @@
`default_nettype none

// Reference-counted entry allocator for a pool of rea_pkg::NUM_ENTRIES entries.
// Request channel: drive req_cmd and req_entry_index with start high; the
// transaction is taken at a rising edge where start is high and busy is low.
// Commands are allocate (pops a free index), retain (count up, saturating at
// 255) and release (count down, or at a count of zero free the entry and put
// its index back on the free stack). Other command codes change nothing.
// Response channel: rsp_valid is high for exactly one cycle with rsp_status,
// rsp_result_index and rsp_ref_count. The receiver cannot stall it.
// Each transaction is a registered read of the free stack and count
// memories at acceptance, then an execute step that computes, writes them
// back and registers the result; no new transaction is taken during execute.
// Busy falls as the result is shown, so the next transaction can be accepted
// in the same cycle as that result strobe.
// Reset (synchronous) marks every entry free with the stack in index order;
// no clearing pass is needed, so the block takes requests right after reset.

module refcounted_entry_allocator_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [rea_pkg::CMD_W-1:0]     req_cmd,
   input  wire logic [rea_pkg::IDX_W-1:0]     req_entry_index,
   output logic                               rsp_valid,
   output logic [rea_pkg::STATUS_W-1:0]       rsp_status,
   output logic [rea_pkg::IDX_W-1:0]          rsp_result_index,
   output logic [rea_pkg::COUNT_W-1:0]        rsp_ref_count
);
   import rea_pkg::*;

   ctl_cmd_type ctl;

   rea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl)
   );

   rea_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .req_cmd          (req_cmd),
      .req_entry_index  (req_entry_index),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index),
      .rsp_ref_count    (rsp_ref_count)
   );

endmodule

`default_nettype wire

@@ tb/sv/tb_refcounted_entry_allocator_unit.sv @@
`timescale 1ns / 1ps

module tb_refcounted_entry_allocator_unit;
   import rea_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 750;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_MAX   = 10;

   typedef struct {
      status_type       status;
      logic [IDX_W-1:0]   index;
      logic [COUNT_W-1:0] count;
   } alloc_result_type;

   // Tracks the free stack, counts and in-use marks, and holds the results
   // owed by the block in issue order.
   class alloc_scoreboard;
      logic [IDX_W-1:0]   free_stack [NUM_ENTRIES];
      int                 free_fill;
      logic [COUNT_W-1:0] counts     [NUM_ENTRIES];
      bit                 in_use     [NUM_ENTRIES];
      alloc_result_type   owed[$];
      int                 mismatches;

      function new();
         for (int k = 0; k < NUM_ENTRIES; k++) begin
            free_stack[k] = IDX_W'(k);
            counts[k]     = '0;
            in_use[k]     = 1'b0;
         end
         free_fill  = NUM_ENTRIES;
         mismatches = 0;
      endfunction

      function void owe(status_type st, logic [IDX_W-1:0] idx, logic [COUNT_W-1:0] cnt);
         alloc_result_type r;
         r.status = st;
         r.index  = idx;
         r.count  = cnt;
         owed.push_back(r);
      endfunction

      function void note_request(cmd_type op, logic [IDX_W-1:0] idx);
         bit               live;
         logic [IDX_W-1:0] got;
         live = (int'(idx) < NUM_ENTRIES) && in_use[int'(idx)];
         if (op == CMD_ALLOC) begin
            if (free_fill == 0) begin
               owe(STAT_EMPTY, '0, '0);
            end else begin
               free_fill--;
               got = free_stack[free_fill];
               counts[int'(got)] = '0;
               in_use[int'(got)] = 1'b1;
               owe(STAT_OK, got, '0);
            end
         end else if (op == CMD_NOP) begin
            owe(STAT_OK, idx, '0);
         end else if (!live) begin
            owe(STAT_NOT_IN_USE, idx, '0);
         end else if (op == CMD_RETAIN) begin
            if (counts[int'(idx)] >= COUNT_LIMIT) begin
               owe(STAT_SATURATED, idx, COUNT_LIMIT);
            end else begin
               counts[int'(idx)]++;
               owe(STAT_OK, idx, counts[int'(idx)]);
            end
         end else if (counts[int'(idx)] != '0) begin
            counts[int'(idx)]--;
            owe(STAT_OK, idx, counts[int'(idx)]);
         end else begin
            // The last reference is gone, so the index goes back on the stack.
            in_use[int'(idx)] = 1'b0;
            if (free_fill < NUM_ENTRIES) begin
               free_stack[free_fill] = idx;
               free_fill++;
            end
            owe(STAT_FREED, idx, '0);
         end
      endfunction

      function void check_result(logic [STATUS_W-1:0] st, logic [IDX_W-1:0] idx,
                                 logic [COUNT_W-1:0] cnt);
         alloc_result_type r;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("mismatch: result with none outstanding: status %0d index %0d count %0d",
                        st, idx, cnt);
            return;
         end
         r = owed.pop_front();
         if (st !== r.status || idx !== r.index || cnt !== r.count) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
               $display("mismatch: expected status %0d index %0d count %0d, got %0d %0d %0d",
                        r.status, r.index, r.count, st, idx, cnt);
         end
      endfunction

      function int outstanding();
         return owed.size();
      endfunction

      function int pick_live();
         int live_list[$];
         for (int k = 0; k < NUM_ENTRIES; k++)
            if (in_use[k]) live_list.push_back(k);
         if (live_list.size() == 0) return -1;
         return live_list[$urandom_range(0, live_list.size() - 1)];
      endfunction

      function int count_of(int idx);
         return int'(counts[idx]);
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic [CMD_W-1:0]    req_cmd;
   logic [IDX_W-1:0]    req_entry_index;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [IDX_W-1:0]    rsp_result_index;
   logic [COUNT_W-1:0]  rsp_ref_count;

   alloc_scoreboard sb = new();
   int              cycle_count = 0;
   int              items_sent  = 0;
   bit              quiet       = 1'b0;

   refcounted_entry_allocator_unit uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_entry_index  (req_entry_index),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_result_index (rsp_result_index),
      .rsp_ref_count    (rsp_ref_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL refcounted_entry_allocator_unit");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_status, rsp_result_index, rsp_ref_count);
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Holds start until the transaction is taken, then idles for a random gap
   // with junk on the request fields.
   task automatic send_op(input cmd_type op, input logic [IDX_W-1:0] idx);
      int gap;
      @(negedge clock);
      start           = 1'b1;
      req_cmd         = op;
      req_entry_index = idx;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      sb.note_request(op, idx);
      items_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start           = 1'b0;
         req_cmd         = CMD_W'($urandom_range(0, 3));
         req_entry_index = IDX_W'($urandom_range(0, 255));
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic live_or_alloc(output int idx);
      idx = sb.pick_live();
      if (idx < 0) begin
         send_op(CMD_ALLOC, '0);
         idx = sb.pick_live();
      end
   endtask

   task automatic saturate_one();
      int idx;
      int n;
      live_or_alloc(idx);
      if (idx < 0) return;
      n = 256 - sb.count_of(idx) + $urandom_range(1, 3);
      repeat (n) send_op(CMD_RETAIN, IDX_W'(idx));
   endtask

   task automatic run_random();
      int  r;
      int  idx;
      int  n;
      bit  sat_a;
      bit  sat_b;
      sat_a = 1'b0;
      sat_b = 1'b0;
      while (items_sent < RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 5) == 0);
         r = $urandom_range(0, 99);
         if (!sat_a && items_sent >= 150) begin
            sat_a = 1'b1;
            saturate_one();
         end else if (!sat_b && items_sent >= 450) begin
            sat_b = 1'b1;
            saturate_one();
         end else if (r < 25) begin
            // Now and then allocate past the pool size to hit exhaustion.
            n = ($urandom_range(0, 7) == 0) ? 70 : $urandom_range(1, 6);
            repeat (n) send_op(CMD_ALLOC, IDX_W'($urandom_range(0, 255)));
         end else if (r < 50) begin
            live_or_alloc(idx);
            if (idx >= 0)
               repeat ($urandom_range(1, 5)) send_op(CMD_RETAIN, IDX_W'(idx));
         end else if (r < 75) begin
            live_or_alloc(idx);
            if (idx >= 0) begin
               if (sb.count_of(idx) > 20)
                  n = $urandom_range(1, 4);
               else
                  n = sb.count_of(idx) + 1 + ($urandom_range(0, 3) == 0);
               repeat (n) send_op(CMD_RELEASE, IDX_W'(idx));
            end
         end else if (r < 85) begin
            live_or_alloc(idx);
            if (idx >= 0)
               repeat ($urandom_range(1, 3)) send_op(CMD_RELEASE, IDX_W'(idx));
         end else begin
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1) == 0)
                  idx = $urandom_range(0, 255);
               else
                  idx = $urandom_range(0, NUM_ENTRIES - 1);
               send_op(cmd_type'($urandom_range(0, 3)), IDX_W'(idx));
            end
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_cmd         = CMD_ALLOC;
      req_entry_index = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: one entry through its whole life, then the corner indices.
      send_op(CMD_ALLOC, '0);
      send_op(CMD_RETAIN, 8'd63);
      send_op(CMD_RETAIN, 8'd63);
      send_op(CMD_RELEASE, 8'd63);
      send_op(CMD_RELEASE, 8'd63);
      send_op(CMD_RELEASE, 8'd63);
      send_op(CMD_RELEASE, 8'd63);
      send_op(CMD_RETAIN, 8'd63);
      send_op(CMD_RETAIN, 8'd255);
      send_op(CMD_RELEASE, 8'd64);
      send_op(CMD_NOP, 8'd255);
      send_op(CMD_NOP, 8'd0);
      send_op(CMD_RETAIN, 8'd0);
      send_op(CMD_ALLOC, 8'd255);
      send_op(CMD_ALLOC, '0);
      send_op(CMD_RELEASE, 8'd62);
      send_op(CMD_ALLOC, '0);
      send_op(CMD_RETAIN, 8'hAA);
      send_op(CMD_RELEASE, 8'h55);
      send_op(CMD_RETAIN, 8'd62);

      run_random();

      @(negedge clock);
      start = 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("PASS refcounted_entry_allocator_unit");
      end else begin
         $display("FAIL refcounted_entry_allocator_unit");
      end
      $finish;
   end

endmodule
